[rtl/bhpq_pkg.sv]
// Shared types and codes for the binary heap priority queue.
// Action and status codes, parameter defaults, controller/datapath interface.
// No dependencies.
package bhpq_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_BITS_DEF  = 16;
   localparam int DATA_BITS_DEF = 32;

   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic load_req;
      logic ins_start;
      logic rem_start;
      logic set_full;
      logic set_empty;
      logic clear;
      logic up_read;
      logic dn_read;
      logic rem_load;
      logic wr_elem;
      logic up_move;
      logic dn_move;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic pos_root;
      logic dn_leaf;
      logic up_swap;
      logic dn_swap;
   } stat_type;

endpackage

[rtl/bhpq_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module bhpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a_ff,
   output logic [WIDTH-1:0]         rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

[rtl/bhpq_ctrl.sv]
// Sequencer for the heap queue: accepts a request, steps sift-up or sift-down
// and hands the result to the output register. Depends on bhpq_pkg.
module bhpq_ctrl
   import bhpq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ACT_W-1:0] req_action,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  stat_type         stat,
   output cmd_type          cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_RM_LOAD,
      ST_DN_CHK,
      ST_DN_CMP,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               case (req_action)
                  ACT_INSERT: begin
                     if (stat.count_full) begin
                        cmd.set_full = 1'b1;
                        state_in     = ST_RESULT;
                     end else begin
                        cmd.ins_start = 1'b1;
                        state_in      = ST_UP_CHK;
                     end
                  end
                  ACT_REMOVE: begin
                     if (stat.count_zero) begin
                        cmd.set_empty = 1'b1;
                        state_in      = ST_RESULT;
                     end else begin
                        cmd.rem_start = 1'b1;
                        state_in      = ST_RM_LOAD;
                     end
                  end
                  ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_RESULT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_UP_CHK: begin
            if (stat.pos_root) begin
               cmd.wr_elem = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_swap) begin
               cmd.up_move = 1'b1;
               state_in    = ST_UP_CHK;
            end else begin
               cmd.wr_elem = 1'b1;
               state_in    = ST_RESULT;
            end
         end
         ST_RM_LOAD: begin
            cmd.rem_load = 1'b1;
            state_in     = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (stat.dn_leaf) begin
               cmd.wr_elem = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               cmd.dn_read = 1'b1;
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (stat.dn_swap) begin
               cmd.dn_move = 1'b1;
               state_in    = ST_DN_CHK;
            end else begin
               cmd.wr_elem = 1'b1;
               state_in    = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

[rtl/bhpq_dp.sv]
// Datapath of the heap queue: heap RAM, fill count, moving entry, result and
// output registers, order register. Depends on bhpq_pkg and bhpq_ram.
module bhpq_dp
   import bhpq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_order,
   input  logic [KEY_BITS-1:0]  in_key,
   input  logic [DATA_BITS-1:0] in_data,
   input  cmd_type              cmd,
   output stat_type             stat,
   output logic [KEY_BITS-1:0]  out_key,
   output logic [DATA_BITS-1:0] out_data,
   output logic [STAT_W-1:0]    out_status,
   output logic [CNT_W-1:0]     out_count,
   output logic                 out_empty,
   output logic                 out_full
);

   localparam int AW = $clog2(CAPACITY);
   localparam int IW = AW + 2;
   localparam int EW = KEY_BITS + DATA_BITS;

   logic                 order_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [KEY_BITS-1:0]  elem_key_ff, elem_key_in;
   logic [DATA_BITS-1:0] elem_data_ff, elem_data_in;
   logic [KEY_BITS-1:0]  res_key_ff, res_key_in;
   logic [DATA_BITS-1:0] res_data_ff, res_data_in;
   logic [STAT_W-1:0]    res_status_ff, res_status_in;
   logic [KEY_BITS-1:0]  out_key_ff;
   logic [DATA_BITS-1:0] out_data_ff;
   logic [STAT_W-1:0]    out_status_ff;
   logic [CNT_W-1:0]     out_count_ff;
   logic                 out_empty_ff, out_full_ff;

   logic [EW-1:0]        rd_a, rd_b, best, wr_data;
   logic [AW-1:0]        rd_addr_a, rd_addr_b, parent, best_idx;
   logic [IW-1:0]        left_x, right_x, count_x;
   logic                 wr_en, right_better;

   function automatic logic ranks_above(input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b,
                                        input logic                mode);
      return mode ? (a > b) : (a < b);
   endfunction

   assign left_x  = IW'({pos_ff, 1'b1});
   assign right_x = left_x + IW'(1);
   assign count_x = IW'(count_ff);
   assign parent  = AW'((pos_ff - AW'(1)) >> 1);

   assign right_better = (right_x < count_x) &&
                         ranks_above(rd_b[KEY_BITS-1:0], rd_a[KEY_BITS-1:0], order_ff);
   assign best     = right_better ? rd_b : rd_a;
   assign best_idx = right_better ? right_x[AW-1:0] : left_x[AW-1:0];

   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff == CNT_W'(CAPACITY));
   assign stat.pos_root   = (pos_ff == '0);
   assign stat.dn_leaf    = (left_x >= count_x);
   assign stat.up_swap    = ranks_above(elem_key_ff, rd_a[KEY_BITS-1:0], order_ff);
   assign stat.dn_swap    = ranks_above(best[KEY_BITS-1:0], elem_key_ff, order_ff);

   assign rd_addr_a = cmd.rem_start ? '0 : (cmd.up_read ? parent : left_x[AW-1:0]);
   assign rd_addr_b = cmd.rem_start ? AW'(count_ff - CNT_W'(1)) : right_x[AW-1:0];

   assign wr_en   = cmd.wr_elem | cmd.up_move | cmd.dn_move;
   assign wr_data = cmd.wr_elem ? {elem_data_ff, elem_key_ff} :
                    (cmd.up_move ? rd_a : best);

   bhpq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (pos_ff),
      .wr_data      (wr_data),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .rd_data_a_ff (rd_a),
      .rd_data_b_ff (rd_b)
   );

   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      elem_key_in   = elem_key_ff;
      elem_data_in  = elem_data_ff;
      res_key_in    = res_key_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      if (cmd.load_req) begin
         res_key_in    = '0;
         res_data_in   = '0;
         res_status_in = STAT_OK;
      end
      if (cmd.set_full) begin
         res_status_in = STAT_FULL;
      end
      if (cmd.set_empty) begin
         res_status_in = STAT_EMPTY;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.ins_start) begin
         elem_key_in  = in_key;
         elem_data_in = in_data;
         pos_in       = AW'(count_ff);
         count_in     = count_ff + CNT_W'(1);
      end
      if (cmd.rem_start) begin
         pos_in   = '0;
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.rem_load) begin
         res_key_in   = rd_a[KEY_BITS-1:0];
         res_data_in  = rd_a[EW-1:KEY_BITS];
         elem_key_in  = rd_b[KEY_BITS-1:0];
         elem_data_in = rd_b[EW-1:KEY_BITS];
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.dn_move) begin
         pos_in = best_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            order_ff <= csr_order;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      elem_key_ff   <= elem_key_in;
      elem_data_ff  <= elem_data_in;
      res_key_ff    <= res_key_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      if (cmd.emit) begin
         out_key_ff    <= res_key_ff;
         out_data_ff   <= res_data_ff;
         out_status_ff <= res_status_ff;
         out_count_ff  <= count_ff;
         out_empty_ff  <= (count_ff == '0);
         out_full_ff   <= (count_ff == CNT_W'(CAPACITY));
      end
   end

   assign out_key    = out_key_ff;
   assign out_data   = out_data_ff;
   assign out_status = out_status_ff;
   assign out_count  = out_count_ff;
   assign out_empty  = out_empty_ff;
   assign out_full   = out_full_ff;

endmodule

[rtl/binary_heap_priority_queue.sv]
// Top level of the binary heap priority queue: controller, datapath, ports.
// Depends on bhpq_pkg, bhpq_ctrl, bhpq_dp (and bhpq_ram below it).
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tuser: action; tdata: in_key, in_data
//  rsp     | out | rsp_tvalid/tready   | tuser: status; tdata: key, data, count, flags
//  csr     | in  | csr_valid/csr_ready | csr_data: order_mode
//
// One request at a time. Clear, rejected and unknown requests go straight to the result
// state; insert steps a check and a compare per level climbed, remove a load, then a
// check and a compare per level descended, each compare using the registered RAM read.
// Synchronous reset empties the queue and selects smallest-first order.
// A stalled result waits in the output register while the next request is taken.
module binary_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF,
   localparam int CNT_W    = $clog2(CAPACITY + 1),
   localparam int IN_W     = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
   localparam int OUT_W    = ((KEY_BITS + DATA_BITS + CNT_W + 2 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_W-1:0]   req_tdata,   // in_key, in_data, zero pad
   input  logic [ACT_W-1:0]  req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata,   // out_key, out_data, entry_count, is_empty, is_full, pad
   output logic [STAT_W-1:0] rsp_tuser,   // status
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int OFF_CNT = KEY_BITS + DATA_BITS;
   localparam int PAD_W   = OUT_W - OFF_CNT - CNT_W - 2;

   cmd_type              cmd;
   stat_type             stat;
   logic [KEY_BITS-1:0]  out_key;
   logic [DATA_BITS-1:0] out_data;
   logic [CNT_W-1:0]     out_count;
   logic                 out_empty, out_full;

   assign csr_ready = 1'b1;

   bhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bhpq_dp #(
      .CAPACITY  (CAPACITY),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid),
      .csr_order  (csr_data),
      .in_key     (req_tdata[KEY_BITS-1:0]),
      .in_data    (req_tdata[KEY_BITS +: DATA_BITS]),
      .cmd        (cmd),
      .stat       (stat),
      .out_key    (out_key),
      .out_data   (out_data),
      .out_status (rsp_tuser),
      .out_count  (out_count),
      .out_empty  (out_empty),
      .out_full   (out_full)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, out_full, out_empty, out_count, out_data, out_key};

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_full_status_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_FULL) |->
         (rsp_tdata[OFF_CNT +: CNT_W] == CNT_W'(CAPACITY)))
      else $error("full rejection with queue not full");

   a_empty_status_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_EMPTY) |->
         (rsp_tdata[OFF_CNT-1:0] == '0 && rsp_tdata[OFF_CNT +: CNT_W] == '0))
      else $error("empty rejection with non-zero entry or count");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[OFF_CNT +: CNT_W] <= CNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

endmodule

[tb/tb_binary_heap_priority_queue.sv]
// Self-checking testbench for binary_heap_priority_queue: a directed table, then random
// fill, drain and mixed runs under both orders, checked against an in-bench heap model.
// Depends on bhpq_pkg and the binary_heap_priority_queue RTL.
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;
   import bhpq_pkg::*;

   localparam int HEAP_DEPTH = 64;
   localparam int PHASE_ITEMS = 265;
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [15:0]       key;
      logic [31:0]       data;
      logic [STAT_W-1:0] status;
      logic [6:0]        count;
      logic              is_empty;
      logic              is_full;
   } rsp_item_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic [15:0]      key;
      logic [31:0]      data;
      logic             typed;
      rsp_item_type     want;
   } dir_row_type;

   typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [47:0]       req_tdata = '0;
   logic [ACT_W-1:0]  req_tuser = ACT_INSERT;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data = 1'b0;

   logic [15:0] heap_key [HEAP_DEPTH];
   logic [31:0] heap_val [HEAP_DEPTH];
   int          heap_fill = 0;
   logic        serve_largest = 1'b0;

   rsp_item_type pending_rsps [$];
   int           mismatch_count = 0;
   int           req_count = 0;
   bit           req_quiet = 1'b0;

   dir_row_type directed_rows [23] = '{
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_EMPTY, 7'd0, 1'b1, 1'b0}},
      '{ACT_NONE,   16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd0, 1'b1, 1'b0}},
      '{ACT_CLEAR,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd0, 1'b1, 1'b0}},
      '{ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd1, 1'b0, 1'b0}},
      '{ACT_INSERT, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_INSERT, 16'h8000, 32'h1234_5678, 1'b0, '0},
      '{ACT_INSERT, 16'h0001, 32'hA5A5_A5A5, 1'b0, '0},
      '{ACT_INSERT, 16'h0001, 32'h5A5A_5A5A, 1'b0, '0},
      '{ACT_INSERT, 16'h7FFF, 32'hDEAD_BEEF, 1'b0, '0},
      '{ACT_NONE,   16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd5, 1'b0, 1'b0}},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_EMPTY, 7'd0, 1'b1, 1'b0}},
      '{ACT_INSERT, 16'h1234, 32'hCAFE_F00D, 1'b0, '0},
      '{ACT_INSERT, 16'h4321, 32'h0BAD_F00D, 1'b0, '0},
      '{ACT_CLEAR,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd0, 1'b1, 1'b0}},
      '{ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_EMPTY, 7'd0, 1'b1, 1'b0}},
      '{ACT_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd1, 1'b0, 1'b0}},
      '{ACT_CLEAR,  16'h0000, 32'h0000_0000, 1'b1, '{16'h0, 32'h0, STAT_OK, 7'd0, 1'b1, 1'b0}}
   };

   binary_heap_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10ms;
      $display("** binary_heap_priority_queue: FAILED **");
      $finish;
   end

   function automatic bit ranks_above(logic [15:0] a, logic [15:0] b);
      return serve_largest ? (a > b) : (a < b);
   endfunction

   function automatic void swap_entries(int i, int j);
      logic [15:0] k;
      logic [31:0] d;
      k = heap_key[i];
      d = heap_val[i];
      heap_key[i] = heap_key[j];
      heap_val[i] = heap_val[j];
      heap_key[j] = k;
      heap_val[j] = d;
   endfunction

   function automatic rsp_item_type predict_response(logic [ACT_W-1:0] act, logic [15:0] key,
                                                    logic [31:0] data);
      rsp_item_type r;
      int pos;
      int parent;
      int best;
      bit done;
      r = '0;
      r.status = STAT_OK;
      if (act == ACT_INSERT) begin
         if (heap_fill >= HEAP_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            pos = heap_fill;
            heap_key[pos] = key;
            heap_val[pos] = data;
            heap_fill++;
            done = 1'b0;
            while (pos > 0 && !done) begin
               parent = (pos - 1) / 2;
               if (ranks_above(heap_key[pos], heap_key[parent])) begin
                  swap_entries(pos, parent);
                  pos = parent;
               end else begin
                  done = 1'b1;
               end
            end
         end
      end else if (act == ACT_REMOVE) begin
         if (heap_fill == 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.key = heap_key[0];
            r.data = heap_val[0];
            heap_fill--;
            heap_key[0] = heap_key[heap_fill];
            heap_val[0] = heap_val[heap_fill];
            pos = 0;
            done = 1'b0;
            while (!done) begin
               if (2 * pos + 1 >= heap_fill) begin
                  done = 1'b1;
               end else begin
                  best = 2 * pos + 1;
                  if (best + 1 < heap_fill && ranks_above(heap_key[best + 1], heap_key[best]))
                     best = best + 1;
                  if (ranks_above(heap_key[best], heap_key[pos])) begin
                     swap_entries(pos, best);
                     pos = best;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
      end else if (act == ACT_CLEAR) begin
         heap_fill = 0;
      end
      r.count = heap_fill[6:0];
      r.is_empty = (heap_fill == 0);
      r.is_full = (heap_fill == HEAP_DEPTH);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 40)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(input logic [ACT_W-1:0] act, input logic [15:0] key,
                               input logic [31:0] data, input logic typed,
                               input rsp_item_type typed_rsp);
      int gap;
      rsp_item_type want;
      if (req_count % 32 == 0)
         req_quiet = ($urandom_range(0, 3) == 0);
      gap = req_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {data, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = predict_response(act, key, data);
      pending_rsps.push_back(typed ? typed_rsp : want);
      req_count++;
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_order(input logic mode);
      csr_valid <= 1'b1;
      csr_data <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      serve_largest = mode;
   endtask

   task automatic pick_request(input trend_type trend, output logic [ACT_W-1:0] act,
                               output logic [15:0] key, output logic [31:0] data);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (trend)
         TREND_FILL:  act = (roll < 90) ? ACT_INSERT : ACT_REMOVE;
         TREND_DRAIN: act = (roll < 85) ? ACT_REMOVE : ACT_INSERT;
         default:     act = (roll < 50) ? ACT_INSERT : ACT_REMOVE;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2)
         act = ACT_NONE;
      else if (roll < 3 && trend != TREND_FILL)
         act = ACT_CLEAR;
      case ($urandom_range(0, 7))
         0:       key = 16'h0000;
         1:       key = 16'hFFFF;
         2, 3:    key = 16'($urandom_range(0, 7));
         default: key = 16'($urandom);
      endcase
      data = $urandom;
   endtask

   initial begin
      int unsigned stall;
      int n;
      bit quiet;
      n = 0;
      quiet = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (n % 32 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         stall = quiet ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         n++;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_tdata, '0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_tdata[15:0] !== want.key)
               report_mismatch("out_key", rsp_tdata[15:0], want.key);
            if (rsp_tdata[47:16] !== want.data)
               report_mismatch("out_data", rsp_tdata[47:16], want.data);
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[54:48] !== want.count)
               report_mismatch("entry_count", rsp_tdata[54:48], want.count);
            if (rsp_tdata[55] !== want.is_empty)
               report_mismatch("is_empty", rsp_tdata[55], want.is_empty);
            if (rsp_tdata[56] !== want.is_full)
               report_mismatch("is_full", rsp_tdata[56], want.is_full);
            if (rsp_tdata[63:57] !== 7'd0)
               report_mismatch("pad", rsp_tdata[63:57], 0);
         end
      end
   end

   initial begin
      logic [ACT_W-1:0] act;
      logic [15:0] key;
      logic [31:0] data;
      trend_type trend;
      int run_len;
      int sent;
      int k;
      bit first_run;
      @(posedge clock);
      while (reset) @(posedge clock);

      write_order(1'b0);
      foreach (directed_rows[i])
         send_request(directed_rows[i].act, directed_rows[i].key, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);

      // alternate order per phase; entries carry over so a new order meets a filled heap
      for (int ph = 0; ph < 5; ph++) begin
         drain_responses();
         write_order((ph % 2 == 0) ? 1'b1 : 1'b0);
         sent = 0;
         first_run = 1'b1;
         while (sent < PHASE_ITEMS) begin
            trend = first_run ? TREND_FILL : trend_type'($urandom_range(0, 2));
            run_len = first_run ? 100 : $urandom_range(30, 100);
            first_run = 1'b0;
            for (k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
               pick_request(trend, act, key, data);
               send_request(act, key, data, 1'b0, '0);
               if (act != ACT_NONE)
                  sent++;
            end
         end
      end

      drain_responses();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0)
         $display("** binary_heap_priority_queue: PASSED **");
      else
         $display("** binary_heap_priority_queue: FAILED **");
      $finish;
   end

endmodule

[files.f]
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/bhpq_ctrl.sv
rtl/bhpq_dp.sv
rtl/binary_heap_priority_queue.sv
tb/tb_binary_heap_priority_queue.sv
